FILE: rtl/tpb_pkg.sv
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types, constants and address helpers for the tile picture unit.
// ----------------------------------------------------------------------------
package tpb_pkg;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam int PAT_DEPTH  = 8192;
   localparam int NAME_DEPTH = 2048;
   localparam int PAL_DEPTH  = 32;

   localparam logic [13:0] PAL_BASE    = 14'h3F00;
   localparam logic [14:0] COPY_X_MASK = 15'h041F;
   localparam logic [14:0] COPY_Y_MASK = 15'h7BE0;
   localparam logic [8:0]  DOT_LAST    = 9'd340;
   localparam logic signed [9:0] LINE_LAST    = 10'sd260;
   localparam logic signed [9:0] LINE_PRE     = -10'sd1;
   localparam logic signed [9:0] LINE_VIS_END = 10'sd240;
   localparam logic signed [9:0] LINE_VBLANK  = 10'sd241;
   localparam logic [8:0]  YCOPY_FIRST = 9'd280;
   localparam logic [8:0]  YCOPY_END   = 9'd305;

   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_RBUF,
      PEND_TILE_ID,
      PEND_ATTR,
      PEND_TILE_LO,
      PEND_TILE_HI
   } pend_type;

   typedef struct packed {
      logic        pat_we;
      logic        pat_re;
      logic [12:0] pat_addr;
      logic        name_we;
      logic        name_re;
      logic [10:0] name_addr;
      logic [7:0]  wdata;
   } vram_req_type;

   function automatic logic [10:0] name_idx(input logic [11:0] a, input logic mirror);
      logic bank;
      bank = mirror ? a[11] : a[10];
      return {bank, a[9:0]};
   endfunction

   function automatic logic [4:0] pal_idx(input logic [13:0] a);
      logic [4:0] i;
      i = a[4:0];
      if (i[4] && (i[1:0] == 2'b00)) i[4] = 1'b0;
      return i;
   endfunction

   function automatic logic [14:0] inc_x(input logic [14:0] v);
      logic [14:0] r;
      if (v[4:0] == 5'd31) begin
         r = {v[14:5], 5'd0};
         r[10] = ~r[10];
      end else begin
         r = v + 15'd1;
      end
      return r;
   endfunction

   function automatic logic [14:0] inc_y(input logic [14:0] v);
      logic [14:0] r;
      logic [4:0]  cy;
      r = v;
      if (v[14:12] != 3'b111) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         cy = v[9:5];
         if (cy == 5'd29) begin
            cy = 5'd0;
            r[11] = ~r[11];
         end else if (cy == 5'd31) begin
            cy = 5'd0;
         end else begin
            cy = cy + 5'd1;
         end
         r[9:5] = cy;
      end
      return r;
   endfunction

endpackage

FILE: rtl/tpb_vram.sv
// ----------------------------------------------------------------------------
// tpb_vram
// Pattern and name memories with registered read data and a clearing pass
// that zeroes both after reset.
// ----------------------------------------------------------------------------
module tpb_vram
   import tpb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  vram_req_type vram_req,
   output logic [7:0]   rd_data,
   output logic         clear_busy
);

   logic [7:0]  pat_mem [PAT_DEPTH];
   logic [7:0]  name_mem [NAME_DEPTH];
   logic [7:0]  pat_rd_ff;
   logic [7:0]  name_rd_ff;
   logic        name_sel_ff;
   logic [12:0] clr_cnt_ff;
   logic [12:0] clr_cnt_in;
   logic        busy_ff;
   logic        busy_in;

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 13'd1;
         if (clr_cnt_ff == 13'(PAT_DEPTH - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         pat_mem[clr_cnt_ff] <= 8'd0;
      end else if (vram_req.pat_we) begin
         pat_mem[vram_req.pat_addr] <= vram_req.wdata;
      end
      if (vram_req.pat_re) pat_rd_ff <= pat_mem[vram_req.pat_addr];
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         name_mem[clr_cnt_ff[10:0]] <= 8'd0;
      end else if (vram_req.name_we) begin
         name_mem[vram_req.name_addr] <= vram_req.wdata;
      end
      if (vram_req.name_re) name_rd_ff <= name_mem[vram_req.name_addr];
   end

   always_ff @(posedge clock) begin
      if (vram_req.pat_re || vram_req.name_re) name_sel_ff <= vram_req.name_re;
   end

   assign rd_data = name_sel_ff ? name_rd_ff : pat_rd_ff;
   assign clear_busy = busy_ff;

endmodule

FILE: rtl/tile_ppu_registers_and_background_core.sv
// ----------------------------------------------------------------------------
// tile_ppu_registers_and_background_core
// Tile picture unit: register port, video memory and background pipeline.
// ----------------------------------------------------------------------------
// Each request transfer is a register read, a register write or one dot tick,
// selected by req_type. Every request gives exactly one response transfer
// carrying read data, pixel position, background palette and pixel, the nmi
// pulse and the frame-done flag.
// Responses are registered and appear the cycle after a request is taken; a
// request is taken every cycle while req_stall is low. Memory reads land in a
// registered read port, folded into the fetch latches or read buffer on the
// next cycle, so back-to-back items see their effect without a bubble.
// A response waits in the output register while rsp_stall is high; req_stall
// then rises in the same cycle so no request is lost.
// After reset a clearing pass zeroes pattern and name memory, one entry per
// cycle; requests are stalled meanwhile, csr writes are taken at any time.
// The csr bit (csr_wdata on csr_we) selects vertical (0) or horizontal (1)
// name mirroring.
// ----------------------------------------------------------------------------
module tile_ppu_registers_and_background_core
   import tpb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [2:0]        req_reg_addr,
   input  logic [7:0]        req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   output logic signed [9:0] rsp_pixel_x,
   output logic signed [9:0] rsp_pixel_y,
   output logic [1:0]        rsp_bg_palette,
   output logic [1:0]        rsp_bg_pixel,
   output logic              rsp_nmi_pulse,
   output logic              rsp_frame_done
);

   logic mirror_ff;
   logic [7:0] ctrl_ff, ctrl_in, mask_ff, mask_in;
   logic vblank_ff, vblank_in, toggle_ff, toggle_in;
   logic [2:0] fine_x_ff, fine_x_in;
   logic [14:0] temp_ff, temp_in, cur_ff, cur_in;
   logic [7:0] rbuf_ff, rbuf_in;
   logic [7:0] pal_ff [PAL_DEPTH];
   logic pal_we;
   logic [4:0] pal_a;
   logic [7:0] pal_wd;
   logic [8:0] dot_ff, dot_in;
   logic signed [9:0] line_ff, line_in;
   logic [7:0] tile_id_ff, tile_id_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0] attr_ff, attr_in;
   logic [15:0] sp_lo_ff, sp_lo_in, sp_hi_ff, sp_hi_in, sa_lo_ff, sa_lo_in, sa_hi_ff, sa_hi_in;
   pend_type pend_ff, pend_in;
   logic [1:0] asel_ff, asel_in;
   vram_req_type vram_req;
   logic [7:0] rd_data;
   logic clear_busy;
   logic acc;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] o_rd;
   logic [9:0] o_x, o_y;
   logic [1:0] o_pal, o_pix;
   logic o_nmi, o_done;
   logic [7:0] o_rd_ff;
   logic [9:0] o_x_ff, o_y_ff;
   logic [1:0] o_pal_ff, o_pix_ff;
   logic o_nmi_ff, o_done_ff;
   logic [7:0] rbuf_eff, tile_id_eff, lo_eff, hi_eff;
   logic [1:0] attr_eff, attr_rd;
   logic [13:0] a14;
   logic [14:0] v;
   logic [2:0] ph;
   logic [3:0] bitpos;
   logic in_win, fetch_win, rendering;
   logic [8:0] dot_p1;

   tpb_vram u_vram (
      .clock      (clock),
      .reset      (reset),
      .vram_req   (vram_req),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign req_stall = clear_busy | (rsp_valid_ff & rsp_stall);
   assign acc = req_valid & ~req_stall;

   always_comb begin
      case (asel_ff)
         2'd0: attr_rd = rd_data[1:0];
         2'd1: attr_rd = rd_data[3:2];
         2'd2: attr_rd = rd_data[5:4];
         default: attr_rd = rd_data[7:6];
      endcase
   end

   assign rbuf_eff = (pend_ff == PEND_RBUF) ? rd_data : rbuf_ff;
   assign tile_id_eff = (pend_ff == PEND_TILE_ID) ? rd_data : tile_id_ff;
   assign attr_eff = (pend_ff == PEND_ATTR) ? attr_rd : attr_ff;
   assign lo_eff = (pend_ff == PEND_TILE_LO) ? rd_data : lo_ff;
   assign hi_eff = (pend_ff == PEND_TILE_HI) ? rd_data : hi_ff;

   assign a14 = cur_ff[13:0];
   assign rendering = (mask_ff[4:3] != 2'b00);
   assign ph = dot_ff[2:0] - 3'd1;
   assign dot_p1 = dot_ff + 9'd1;
   assign in_win = (line_ff >= LINE_PRE) && (line_ff < LINE_VIS_END);
   assign fetch_win = ((dot_ff >= 9'd2) && (dot_ff < 9'd258)) ||
                      ((dot_ff >= 9'd321) && (dot_ff < 9'd338));

   always_comb begin
      ctrl_in = ctrl_ff;
      mask_in = mask_ff;
      vblank_in = vblank_ff;
      toggle_in = toggle_ff;
      fine_x_in = fine_x_ff;
      temp_in = temp_ff;
      cur_in = cur_ff;
      rbuf_in = rbuf_eff;
      tile_id_in = tile_id_eff;
      attr_in = attr_eff;
      lo_in = lo_eff;
      hi_in = hi_eff;
      sp_lo_in = sp_lo_ff;
      sp_hi_in = sp_hi_ff;
      sa_lo_in = sa_lo_ff;
      sa_hi_in = sa_hi_ff;
      dot_in = dot_ff;
      line_in = line_ff;
      pend_in = PEND_NONE;
      asel_in = asel_ff;
      vram_req = '0;
      pal_we = 1'b0;
      pal_a = pal_idx(a14);
      pal_wd = req_write_data;
      o_rd = 8'd0;
      o_x = 10'd0;
      o_y = 10'd0;
      o_pal = 2'd0;
      o_pix = 2'd0;
      o_nmi = 1'b0;
      o_done = 1'b0;
      v = cur_ff;
      bitpos = 4'd0;
      if (acc) begin
         case (req_type)
            REQ_READ: begin
               if (req_reg_addr == REG_STATUS) begin
                  o_rd = {vblank_ff, 2'b00, rbuf_eff[4:0]};
                  vblank_in = 1'b0;
                  toggle_in = 1'b0;
               end else if (req_reg_addr == REG_DATA) begin
                  if (a14 >= PAL_BASE) begin
                     o_rd = pal_ff[pal_a];
                     rbuf_in = pal_ff[pal_a];
                  end else begin
                     o_rd = rbuf_eff;
                     pend_in = PEND_RBUF;
                     if (!a14[13]) begin
                        vram_req.pat_re = 1'b1;
                        vram_req.pat_addr = a14[12:0];
                     end else begin
                        vram_req.name_re = 1'b1;
                        vram_req.name_addr = name_idx(a14[11:0], mirror_ff);
                     end
                  end
                  cur_in = cur_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
               end
            end
            REQ_WRITE: begin
               case (req_reg_addr)
                  REG_CTRL: begin
                     ctrl_in = req_write_data;
                     temp_in[11:10] = req_write_data[1:0];
                  end
                  REG_MASK: mask_in = req_write_data;
                  REG_SCROLL: begin
                     if (!toggle_ff) begin
                        fine_x_in = req_write_data[2:0];
                        temp_in[4:0] = req_write_data[7:3];
                        toggle_in = 1'b1;
                     end else begin
                        temp_in[14:12] = req_write_data[2:0];
                        temp_in[9:5] = req_write_data[7:3];
                        toggle_in = 1'b0;
                     end
                  end
                  REG_ADDR: begin
                     if (!toggle_ff) begin
                        temp_in = {1'b0, req_write_data[5:0], temp_ff[7:0]};
                        toggle_in = 1'b1;
                     end else begin
                        temp_in = {temp_ff[14:8], req_write_data};
                        cur_in = {temp_ff[14:8], req_write_data};
                        toggle_in = 1'b0;
                     end
                  end
                  REG_DATA: begin
                     vram_req.wdata = req_write_data;
                     if (!a14[13]) begin
                        vram_req.pat_we = 1'b1;
                        vram_req.pat_addr = a14[12:0];
                     end else if (a14 < PAL_BASE) begin
                        vram_req.name_we = 1'b1;
                        vram_req.name_addr = name_idx(a14[11:0], mirror_ff);
                     end else begin
                        pal_we = 1'b1;
                     end
                     cur_in = cur_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
                  end
                  default: ;
               endcase
            end
            REQ_TICK: begin
               if (in_win) begin
                  if ((line_ff == LINE_PRE) && (dot_ff == 9'd1)) vblank_in = 1'b0;
                  if (fetch_win) begin
                     if (mask_ff[3]) begin
                        sp_lo_in = {sp_lo_ff[14:0], 1'b0};
                        sp_hi_in = {sp_hi_ff[14:0], 1'b0};
                        sa_lo_in = {sa_lo_ff[14:0], 1'b0};
                        sa_hi_in = {sa_hi_ff[14:0], 1'b0};
                     end
                     case (ph)
                        3'd0: begin
                           sp_lo_in[7:0] = lo_eff;
                           sp_hi_in[7:0] = hi_eff;
                           sa_lo_in[7:0] = {8{attr_eff[0]}};
                           sa_hi_in[7:0] = {8{attr_eff[1]}};
                           vram_req.name_re = 1'b1;
                           vram_req.name_addr = name_idx(cur_ff[11:0], mirror_ff);
                           pend_in = PEND_TILE_ID;
                        end
                        3'd2: begin
                           vram_req.name_re = 1'b1;
                           vram_req.name_addr = name_idx({cur_ff[11:10], 4'hF,
                              cur_ff[9:7], cur_ff[4:2]}, mirror_ff);
                           pend_in = PEND_ATTR;
                           asel_in = {cur_ff[6], cur_ff[1]};
                        end
                        3'd4: begin
                           vram_req.pat_re = 1'b1;
                           vram_req.pat_addr = {ctrl_ff[4], tile_id_eff, 1'b0, cur_ff[14:12]};
                           pend_in = PEND_TILE_LO;
                        end
                        3'd6: begin
                           vram_req.pat_re = 1'b1;
                           vram_req.pat_addr = {ctrl_ff[4], tile_id_eff, 1'b1, cur_ff[14:12]};
                           pend_in = PEND_TILE_HI;
                        end
                        3'd7: if (rendering) v = inc_x(v);
                        default: ;
                     endcase
                  end
                  if ((dot_ff == 9'd256) && rendering) v = inc_y(v);
                  if ((dot_ff == 9'd257) && rendering)
                     v = (v & ~COPY_X_MASK) | (temp_ff & COPY_X_MASK);
                  if ((line_ff == LINE_PRE) && (dot_ff >= YCOPY_FIRST) &&
                      (dot_ff < YCOPY_END) && rendering)
                     v = (v & ~COPY_Y_MASK) | (temp_ff & COPY_Y_MASK);
                  cur_in = v;
               end
               if ((line_ff == LINE_VBLANK) && (dot_ff == 9'd1)) begin
                  vblank_in = 1'b1;
                  o_nmi = ctrl_ff[7];
               end
               if (mask_ff[3]) begin
                  bitpos = 4'd15 - {1'b0, fine_x_ff};
                  o_pix = {sp_hi_in[bitpos], sp_lo_in[bitpos]};
                  o_pal = {sa_hi_in[bitpos], sa_lo_in[bitpos]};
               end
               o_x = {1'b0, dot_ff} - 10'd1;
               o_y = line_ff;
               dot_in = dot_p1;
               if (dot_ff == DOT_LAST) begin
                  dot_in = 9'd0;
                  line_in = line_ff + 10'sd1;
                  if (line_ff == LINE_LAST) begin
                     line_in = LINE_PRE;
                     o_done = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (acc) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
         ctrl_ff <= '0;
         mask_ff <= '0;
         vblank_ff <= 1'b0;
         toggle_ff <= 1'b0;
         fine_x_ff <= '0;
         temp_ff <= '0;
         cur_ff <= '0;
         rbuf_ff <= '0;
         dot_ff <= '0;
         line_ff <= '0;
         tile_id_ff <= '0;
         attr_ff <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
         sp_lo_ff <= '0;
         sp_hi_ff <= '0;
         sa_lo_ff <= '0;
         sa_hi_ff <= '0;
         pend_ff <= PEND_NONE;
         asel_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PAL_DEPTH; i++) pal_ff[i] <= '0;
      end else begin
         if (csr_we) mirror_ff <= csr_wdata;
         ctrl_ff <= ctrl_in;
         mask_ff <= mask_in;
         vblank_ff <= vblank_in;
         toggle_ff <= toggle_in;
         fine_x_ff <= fine_x_in;
         temp_ff <= temp_in;
         cur_ff <= cur_in;
         rbuf_ff <= rbuf_in;
         dot_ff <= dot_in;
         line_ff <= line_in;
         tile_id_ff <= tile_id_in;
         attr_ff <= attr_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         sp_lo_ff <= sp_lo_in;
         sp_hi_ff <= sp_hi_in;
         sa_lo_ff <= sa_lo_in;
         sa_hi_ff <= sa_hi_in;
         pend_ff <= pend_in;
         asel_ff <= asel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pal_we) pal_ff[pal_a] <= pal_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         o_rd_ff <= o_rd;
         o_x_ff <= o_x;
         o_y_ff <= o_y;
         o_pal_ff <= o_pal;
         o_pix_ff <= o_pix;
         o_nmi_ff <= o_nmi;
         o_done_ff <= o_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = o_rd_ff;
   assign rsp_pixel_x = o_x_ff;
   assign rsp_pixel_y = o_y_ff;
   assign rsp_bg_palette = o_pal_ff;
   assign rsp_bg_pixel = o_pix_ff;
   assign rsp_nmi_pulse = o_nmi_ff;
   assign rsp_frame_done = o_done_ff;

   // no request taken while memory is being cleared
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_stall) else $error("request taken during clear");

   // nmi only at the first dot of the vblank line
   a_nmi_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nmi_pulse) |-> (rsp_pixel_y == LINE_VBLANK && rsp_pixel_x == 10'sd0))
      else $error("nmi pulse off position");

   // frame done only on the last dot of the last line
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_pixel_y == LINE_LAST && rsp_pixel_x == 10'sd339))
      else $error("frame done off position");

   // a read of the memory port is always used by the next cycle
   a_pend_once: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != PEND_NONE) |-> $past(acc))
      else $error("pending load without request");

endmodule

FILE: tb/tile_ppu_registers_and_background_core_tb.sv
// ----------------------------------------------------------------------------
// tile_ppu_registers_and_background_core_tb
// Drives register reads, register writes and dot ticks into the picture unit
// and checks every response transfer against a cycle-free model of the
// register port, video memory and background pipeline kept in the bench.
// ----------------------------------------------------------------------------
module tile_ppu_registers_and_background_core_tb
   import tpb_pkg::*;
();

   localparam logic [1:0] REQ_NONE     = 2'd3;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam int CYCLE_LIMIT = 100000;
   localparam int RUN_TICKS   = 200;

   typedef struct packed {
      logic [7:0] rd;
      logic [9:0] px;
      logic [9:0] py;
      logic [1:0] pal;
      logic [1:0] pix;
      logic       nmi;
      logic       done;
   } ppu_rsp_type;

   typedef struct packed {
      logic [1:0] t;
      logic [2:0] r;
      logic [7:0] d;
      logic       typed;
      logic [7:0] rd;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0, csr_wdata = 0;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic [2:0] req_reg_addr = '0;
   logic [7:0] req_write_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_read_data;
   logic signed [9:0] rsp_pixel_x, rsp_pixel_y;
   logic [1:0] rsp_bg_palette, rsp_bg_pixel;
   logic rsp_nmi_pulse, rsp_frame_done;

   tile_ppu_registers_and_background_core dut (.*);

   always #6 clock = ~clock;

   // model state
   logic        mirror_q;
   logic [7:0]  ctrl_q, mask_q, stat_q, rbuf_q;
   logic        wtog_q;
   logic [2:0]  finex_q;
   logic [15:0] tv_q, cv_q;
   logic [7:0]  pat_m [PAT_DEPTH];
   logic [7:0]  nm_m [NAME_DEPTH];
   logic [7:0]  pl_m [PAL_DEPTH];
   int          dot_q, line_q;
   logic [7:0]  tid_q, at_q, tlo_q, thi_q;
   logic [15:0] sp_lo, sp_hi, sa_lo, sa_hi;

   ppu_rsp_type rsp_due[$];
   int       fails = 0;
   int       cycles = 0;
   logic     calm = 0;
   int       hold_asks = 0, hold_seen = 0, hold_cnt = 0;

   function automatic logic [10:0] name_slot(input logic [15:0] a);
      return {mirror_q ? a[11] : a[10], a[9:0]};
   endfunction

   function automatic logic [4:0] pal_slot(input logic [15:0] a);
      logic [4:0] i;
      i = a[4:0];
      if ((i & 5'h13) == 5'h10) i = i & 5'h0F;
      return i;
   endfunction

   function automatic logic [7:0] vram_rd(input logic [15:0] a);
      a = a & 16'h3FFF;
      if (a < 16'h2000) return pat_m[a[12:0]];
      if (a < 16'h3F00) return nm_m[name_slot(a & 16'h0FFF)];
      return pl_m[pal_slot(a)];
   endfunction

   function automatic void vram_wr(input logic [15:0] a, input logic [7:0] d);
      a = a & 16'h3FFF;
      if (a < 16'h2000) pat_m[a[12:0]] = d;
      else if (a < 16'h3F00) nm_m[name_slot(a & 16'h0FFF)] = d;
      else pl_m[pal_slot(a)] = d;
   endfunction

   function automatic logic drawing();
      return mask_q[4:3] != 2'b00;
   endfunction

   function automatic void data_port_step();
      cv_q = (cv_q + (ctrl_q[2] ? 16'd32 : 16'd1)) & 16'h7FFF;
   endfunction

   function automatic void coarse_x_step();
      if (!drawing()) return;
      if (cv_q[4:0] == 5'd31) cv_q = (cv_q & ~16'h001F) ^ 16'h0400;
      else cv_q = cv_q + 16'd1;
   endfunction

   function automatic void fine_y_step();
      logic [15:0] v;
      logic [4:0]  cy;
      if (!drawing()) return;
      v = cv_q;
      if (v[14:12] != 3'b111) begin
         cv_q = v + 16'h1000;
         return;
      end
      v = v & ~16'h7000;
      cy = v[9:5];
      if (cy == 5'd29) begin
         cy = 0;
         v = v ^ 16'h0800;
      end else if (cy == 5'd31) begin
         cy = 0;
      end else begin
         cy = cy + 5'd1;
      end
      v[9:5] = cy;
      cv_q = v;
   endfunction

   function automatic void bg_fetch(input int ph);
      logic [15:0] v, a, base;
      v = cv_q;
      base = (ctrl_q[4] ? 16'h1000 : 16'h0) + {4'd0, tid_q, 4'd0} + {13'd0, v[14:12]};
      case (ph)
         0: begin
            sp_lo = {sp_lo[15:8], tlo_q};
            sp_hi = {sp_hi[15:8], thi_q};
            sa_lo = {sa_lo[15:8], {8{at_q[0]}}};
            sa_hi = {sa_hi[15:8], {8{at_q[1]}}};
            tid_q = vram_rd(16'h2000 | (v & 16'h0FFF));
         end
         2: begin
            a = 16'h23C0 | (v & 16'h0C00) | {10'd0, v[9:7], 3'd0} | {13'd0, v[4:2]};
            at_q = vram_rd(a);
            if (v[6]) at_q = at_q >> 4;
            if (v[1]) at_q = at_q >> 2;
            at_q = at_q & 8'd3;
         end
         4: tlo_q = vram_rd(base);
         6: thi_q = vram_rd(base + 16'd8);
         7: coarse_x_step();
         default: ;
      endcase
   endfunction

   function automatic ppu_rsp_type ppu_step(input logic [1:0] t, input logic [2:0] r,
                                            input logic [7:0] d);
      ppu_rsp_type o;
      int dot, line;
      logic [15:0] m;
      o = '0;
      if (t == REQ_READ) begin
         if (r == REG_STATUS) begin
            o.rd = (stat_q & 8'hE0) | (rbuf_q & 8'h1F);
            stat_q = stat_q & 8'h7F;
            wtog_q = 0;
         end else if (r == REG_DATA) begin
            o.rd = rbuf_q;
            rbuf_q = vram_rd(cv_q);
            if ((cv_q & 16'h3FFF) >= 16'h3F00) o.rd = rbuf_q;
            data_port_step();
         end
      end else if (t == REQ_WRITE) begin
         case (r)
            REG_CTRL: begin
               ctrl_q = d;
               tv_q = (tv_q & ~16'h0C00) | ({14'd0, d[1:0]} << 10);
            end
            REG_MASK: mask_q = d;
            REG_SCROLL: begin
               if (!wtog_q) begin
                  finex_q = d[2:0];
                  tv_q = (tv_q & ~16'h001F) | {11'd0, d[7:3]};
               end else begin
                  tv_q = (tv_q & ~16'h73E0) | ({13'd0, d[2:0]} << 12) | ({11'd0, d[7:3]} << 5);
               end
               wtog_q = ~wtog_q;
            end
            REG_ADDR: begin
               if (!wtog_q) tv_q = (tv_q & 16'h00FF) | ({10'd0, d[5:0]} << 8);
               else begin
                  tv_q = {tv_q[15:8], d};
                  cv_q = tv_q;
               end
               wtog_q = ~wtog_q;
            end
            REG_DATA: begin
               vram_wr(cv_q, d);
               data_port_step();
            end
            default: ;
         endcase
      end else if (t == REQ_TICK) begin
         dot = dot_q;
         line = line_q;
         if (line >= -1 && line < 240) begin
            if (line == -1 && dot == 1) stat_q = stat_q & 8'h7F;
            if ((dot >= 2 && dot < 258) || (dot >= 321 && dot < 338)) begin
               if (mask_q[3]) begin
                  sp_lo = sp_lo << 1;
                  sp_hi = sp_hi << 1;
                  sa_lo = sa_lo << 1;
                  sa_hi = sa_hi << 1;
               end
               bg_fetch((dot - 1) & 7);
            end
            if (dot == 256) fine_y_step();
            if (dot == 257 && drawing()) cv_q = (cv_q & ~16'h041F) | (tv_q & 16'h041F);
            if (line == -1 && dot >= 280 && dot < 305 && drawing())
               cv_q = (cv_q & ~16'h7BE0) | (tv_q & 16'h7BE0);
         end
         if (line == 241 && dot == 1) begin
            stat_q = stat_q | 8'h80;
            o.nmi = ctrl_q[7];
         end
         if (mask_q[3]) begin
            m = 16'h8000 >> finex_q;
            o.pix = {(sp_hi & m) != 0, (sp_lo & m) != 0};
            o.pal = {(sa_hi & m) != 0, (sa_lo & m) != 0};
         end
         o.px = 10'(dot - 1);
         o.py = 10'(line);
         dot_q = dot + 1;
         if (dot_q >= 341) begin
            dot_q = 0;
            line_q = line + 1;
            if (line_q >= 261) begin
               line_q = -1;
               o.done = 1;
            end
         end
      end
      return o;
   endfunction

   // one request transfer, with random idle cycles in front
   task automatic offer(input logic [1:0] t, input logic [2:0] r, input logic [7:0] d,
                        input logic typed = 0, input logic [7:0] rd = 0);
      ppu_rsp_type e;
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_type <= t;
      req_reg_addr <= r;
      req_write_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = ppu_step(t, r, d);
      if (typed) e.rd = rd;
      rsp_due.push_back(e);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mirror(input logic v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      mirror_q = v;
      csr_we <= 0;
   endtask

   task automatic point_at(input logic [7:0] hi, input logic [7:0] lo);
      offer(REQ_READ, REG_STATUS, 8'h00);
      offer(REQ_WRITE, REG_ADDR, hi);
      offer(REQ_WRITE, REG_ADDR, lo);
   endtask

   task automatic fill_vram(input logic [7:0] hi, input logic [7:0] lo, input int n);
      point_at(hi, lo);
      for (int i = 0; i < n; i++) offer(REQ_WRITE, REG_DATA, 8'($urandom));
   endtask

   task automatic random_mix(input int n);
      int k, c;
      logic [7:0] hi;
      c = 0;
      while (c < n) begin
         k = $urandom_range(0, 99);
         if (k < 55) begin
            offer(REQ_TICK, 3'($urandom), 8'($urandom));
            c++;
         end else if (k < 70) begin
            case ($urandom_range(0, 3))
               0: hi = 8'($urandom_range(0, 8'h1F));
               1: hi = 8'($urandom_range(8'h20, 8'h2F));
               2: hi = 8'h3F;
               default: hi = 8'($urandom);
            endcase
            point_at(hi, 8'($urandom));
            repeat ($urandom_range(1, 4))
               offer(k < 62 ? REQ_WRITE : REQ_READ, REG_DATA, 8'($urandom));
            c += 5;
         end else if (k < 76) begin
            offer(REQ_WRITE, REG_SCROLL, 8'($urandom));
            offer(REQ_WRITE, REG_SCROLL, 8'($urandom));
            c += 2;
         end else if (k < 82) begin
            offer(REQ_WRITE, REG_CTRL, 8'($urandom));
            c++;
         end else if (k < 87) begin
            offer(REQ_WRITE, REG_MASK,
                  8'($urandom) | ($urandom_range(0, 9) < 7 ? 8'h18 : 8'h00));
            c++;
         end else if (k < 92) begin
            offer(REQ_READ, REG_STATUS, 8'($urandom));
            c++;
         end else begin
            offer(2'($urandom), 3'($urandom), 8'($urandom));
            c++;
         end
      end
   endtask

   stim_row_type dir_rows [0:24] = '{
      '{REQ_READ,  REG_STATUS,   8'h00, 1'b1, 8'h00},
      '{REQ_READ,  REG_CTRL,     8'h00, 1'b1, 8'h00},
      '{REQ_NONE,  REG_DATA,     8'hFF, 1'b1, 8'h00},
      '{REQ_WRITE, REG_OAM_ADDR, 8'hFF, 1'b0, 8'h00},
      '{REQ_WRITE, REG_OAM_DATA, 8'hFF, 1'b0, 8'h00},
      '{REQ_WRITE, REG_STATUS,   8'hFF, 1'b0, 8'h00},
      '{REQ_READ,  REG_SCROLL,   8'h00, 1'b1, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'hFF, 1'b0, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'h00, 1'b0, 8'h00},
      '{REQ_WRITE, REG_DATA,     8'hA5, 1'b0, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'h3F, 1'b0, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'h10, 1'b0, 8'h00},
      '{REQ_READ,  REG_DATA,     8'h00, 1'b1, 8'hA5},
      '{REQ_WRITE, REG_CTRL,     8'h04, 1'b0, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'h20, 1'b0, 8'h00},
      '{REQ_WRITE, REG_ADDR,     8'h00, 1'b0, 8'h00},
      '{REQ_WRITE, REG_DATA,     8'hFF, 1'b0, 8'h00},
      '{REQ_READ,  REG_DATA,     8'h00, 1'b0, 8'h00},
      '{REQ_WRITE, REG_SCROLL,   8'hFF, 1'b0, 8'h00},
      '{REQ_WRITE, REG_SCROLL,   8'h00, 1'b0, 8'h00},
      '{REQ_WRITE, REG_MASK,     8'hFF, 1'b0, 8'h00},
      '{REQ_TICK,  REG_CTRL,     8'h00, 1'b0, 8'h00},
      '{REQ_TICK,  REG_DATA,     8'hFF, 1'b0, 8'h00},
      '{REQ_WRITE, REG_CTRL,     8'h00, 1'b0, 8'h00},
      '{REQ_WRITE, REG_MASK,     8'h00, 1'b0, 8'h00}
   };

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_cnt <= 400;
         rsp_stall <= 1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
      end
   end

   // response checking
   always @(posedge clock) begin
      ppu_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            $error("response transfer with nothing expected");
            fails++;
         end else begin
            e = rsp_due.pop_front();
            if (rsp_read_data !== e.rd) begin
               $error("read_data expected %0d got %0d", e.rd, rsp_read_data);
               fails++;
            end
            if (rsp_pixel_x !== e.px) begin
               $error("pixel_x expected %0d got %0d", $signed(e.px), rsp_pixel_x);
               fails++;
            end
            if (rsp_pixel_y !== e.py) begin
               $error("pixel_y expected %0d got %0d", $signed(e.py), rsp_pixel_y);
               fails++;
            end
            if (rsp_bg_palette !== e.pal) begin
               $error("bg_palette expected %0d got %0d", e.pal, rsp_bg_palette);
               fails++;
            end
            if (rsp_bg_pixel !== e.pix) begin
               $error("bg_pixel expected %0d got %0d", e.pix, rsp_bg_pixel);
               fails++;
            end
            if (rsp_nmi_pulse !== e.nmi) begin
               $error("nmi_pulse expected %0d got %0d", e.nmi, rsp_nmi_pulse);
               fails++;
            end
            if (rsp_frame_done !== e.done) begin
               $error("frame_done expected %0d got %0d", e.done, rsp_frame_done);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      mirror_q = 0;
      ctrl_q = 0; mask_q = 0; stat_q = 0; rbuf_q = 0;
      wtog_q = 0; finex_q = 0; tv_q = 0; cv_q = 0;
      dot_q = 0; line_q = 0;
      tid_q = 0; at_q = 0; tlo_q = 0; thi_q = 0;
      sp_lo = 0; sp_hi = 0; sa_lo = 0; sa_hi = 0;
      foreach (pat_m[i]) pat_m[i] = 0;
      foreach (nm_m[i]) nm_m[i] = 0;
      foreach (pl_m[i]) pl_m[i] = 0;

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      set_mirror(0);

      foreach (dir_rows[i])
         offer(dir_rows[i].t, dir_rows[i].r, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].rd);

      // pattern, name, attribute and palette content for the fetches
      offer(REQ_WRITE, REG_CTRL, 8'h00);
      fill_vram(8'h00, 8'h00, 64);
      fill_vram(8'h10, 8'h00, 32);
      fill_vram(8'h20, 8'h00, 48);
      fill_vram(8'h23, 8'hC0, 16);
      fill_vram(8'h2C, 8'h00, 16);
      fill_vram(8'h3F, 8'h00, 32);

      hold_asks <= hold_asks + 1;
      random_mix(500);
      drain();
      set_mirror(1);
      fill_vram(8'h28, 8'h00, 24);
      random_mix(500);
      drain();
      set_mirror(0);

      // a run of ticks with drawing and nmi on, first part without idling
      offer(REQ_WRITE, REG_CTRL, 8'h80 | 8'($urandom_range(0, 8'h1F)));
      offer(REQ_WRITE, REG_MASK, 8'h1E);
      calm <= 1;
      for (int i = 0; i < RUN_TICKS; i++) begin
         if (i == 150) calm <= 0;
         if ($urandom_range(0, 499) == 0) offer(REQ_READ, REG_STATUS, 8'h00);
         else offer(REQ_TICK, REG_CTRL, 8'h00);
      end
      drain();
      set_mirror(1);
      random_mix(100);

      req_valid <= 0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fails == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
